// ----- rtl/core/dhd_pkg.sv -----
// Shared constants, codes and a helper function for the double hash dictionary.
package dhd_pkg;

  localparam int TABLE_SIZE_DEF = 4093;
  localparam int MAX_LEN_DEF    = 12;

  localparam int LEN_W      = 4;
  localparam int SYMS_W     = 24;
  localparam int SYM_W      = 2;
  localparam int SLOT_OUT_W = 12;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_t;

  // bits needed for a base-5 key of max_len nonzero digits (max value 5^n - 1)
  function automatic int key_width(input int max_len);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < max_len; i++) begin
      p = p * 5;
    end
    return $clog2(p);
  endfunction

endpackage

// ----- rtl/core/dhd_hash.sv -----
// Key builder: Horner evaluation of the base-5 key plus both probe residues.
module dhd_hash #(
  parameter int TABLE_SIZE = dhd_pkg::TABLE_SIZE_DEF,
  parameter int MAX_LEN    = dhd_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dhd_pkg::LEN_W-1:0]       len_in,
  input  logic [dhd_pkg::SYMS_W-1:0]      symbols_in,
  output logic                            done,
  output logic [dhd_pkg::key_width(MAX_LEN)-1:0] key_o,
  output logic [$clog2(TABLE_SIZE)-1:0]   pos_o,
  output logic [$clog2(TABLE_SIZE)-1:0]   step_o
);
  import dhd_pkg::*;

  localparam int KEY_W  = key_width(MAX_LEN);
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int VW     = SLOT_W + 3;
  localparam int EXT_W  = SYM_W * MAX_LEN;
  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [EXT_W-1:0]    ext_r, ext_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SLOT_W-1:0]   r1_r, r1_nxt;
  logic [SLOT_W-1:0]   r2_r, r2_nxt;
  logic [SYM_W:0]      digit;
  int                  n_i;

  // v < 5*m on entry; remove the largest multiple of m
  function automatic logic [VW-1:0] red5(input logic [VW-1:0] v, input logic [VW-1:0] m);
    logic [VW-1:0] m2;
    logic [VW-1:0] m3;
    logic [VW-1:0] m4;
    m2 = m << 1;
    m3 = m2 + m;
    m4 = m << 2;
    priority if (v >= m4) return v - m4;
    else if (v >= m3) return v - m3;
    else if (v >= m2) return v - m2;
    else if (v >= m) return v - m;
    else return v;
  endfunction

  function automatic logic [SLOT_W-1:0] step5(input logic [SLOT_W-1:0] r,
                                              input logic [SYM_W:0] d,
                                              input logic [VW-1:0] m);
    logic [VW-1:0] v;
    v = VW'({r, 2'b00}) + VW'(r) + VW'(d);
    return SLOT_W'(red5(v, m));
  endfunction

  assign digit = {1'b0, ext_r[{idx_r, 1'b0} +: SYM_W]} + (SYM_W+1)'(1);

  always_comb begin
    n_i = int'(len_in);
    if (n_i < 1) n_i = 1;
    if (n_i > MAX_LEN) n_i = MAX_LEN;

    run_nxt  = run_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    ext_nxt  = ext_r;
    key_nxt  = key_r;
    r1_nxt   = r1_r;
    r2_nxt   = r2_r;
    if (start) begin
      run_nxt = 1'b1;
      idx_nxt = IDX_W'(n_i - 1);
      ext_nxt = EXT_W'(symbols_in);
      key_nxt = '0;
      r1_nxt  = '0;
      r2_nxt  = '0;
    end else if (run_r) begin
      key_nxt = KEY_W'({key_r, 2'b00}) + key_r + KEY_W'(digit);
      r1_nxt  = step5(r1_r, digit, VW'(TABLE_SIZE));
      r2_nxt  = step5(r2_r, digit, VW'(TABLE_SIZE - 1));
      if (idx_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    idx_r <= idx_nxt;
    ext_r <= ext_nxt;
    key_r <= key_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
  end

  assign done   = done_r;
  assign key_o  = key_r;
  assign pos_o  = r1_r;
  assign step_o = r2_r + SLOT_W'(1);

endmodule

// ----- rtl/core/double_hash_dictionary.sv -----
// Double-hashed dictionary of DNA strings: control, probe sequencer and key table.
//
// Usage: items enter on the in_ stream (in_tuser = command, in_tdata = length and
// packed 2-bit symbols); one result per item leaves on the out_ stream
// (out_tuser = found and table_full flags, out_tdata = slot).
// An item is taken only while the sequencer is idle. It then builds the key and
// both residues in the key builder symbol by symbol, issues the first table read,
// and probes slot after slot, since the registered read of the key table is
// reissued every cycle for the next slot; only the final probe can stall.
// A lightly loaded table needs one or two probes; a full table costs
// TABLE_SIZE probes.
// After reset the key table is cleared one entry per cycle, with in_tready low
// during that pass.
// The result sits in an output register; a new item is accepted while it waits,
// and the sequencer holds its final probe until the receiver takes the old result.
module double_hash_dictionary #(
  parameter int TABLE_SIZE = dhd_pkg::TABLE_SIZE_DEF,
  parameter int MAX_LEN    = dhd_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dhd_pkg::IN_DATA_W-1:0] in_tdata,   // [3:0] length, [27:4] symbols
  input  logic                          in_tuser,   // [0] cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dhd_pkg::OUT_DATA_W-1:0] out_tdata, // [11:0] slot
  output logic [1:0]                    out_tuser   // [0] found, [1] table_full
);
  import dhd_pkg::*;

  localparam int KEY_W  = key_width(MAX_LEN);
  localparam int SLOT_W = $clog2(TABLE_SIZE);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HASH  = 4'b0100,
    ST_PROBE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic [SLOT_W-1:0]   step_r, step_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                found_r, found_nxt;
  logic                full_r, full_nxt;
  logic [SLOT_OUT_W-1:0] slot_r, slot_nxt;

  logic [KEY_W-1:0]    mem [TABLE_SIZE];
  logic [KEY_W-1:0]    rd_data_r;
  logic                mem_re;
  logic [SLOT_W-1:0]   mem_raddr;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [KEY_W-1:0]    mem_wdata;

  logic                in_acc;
  logic                hash_done;
  logic [KEY_W-1:0]    hash_key;
  logic [SLOT_W-1:0]   hash_pos;
  logic [SLOT_W-1:0]   hash_step;
  logic                hit, empty, last_probe, out_free;
  logic [SLOT_W:0]     pos_sum;
  logic [SLOT_W-1:0]   pos_adv;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  dhd_hash #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_LEN    (MAX_LEN)
  ) u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .len_in     (in_tdata[LEN_W-1:0]),
    .symbols_in (in_tdata[LEN_W +: SYMS_W]),
    .done       (hash_done),
    .key_o      (hash_key),
    .pos_o      (hash_pos),
    .step_o     (hash_step)
  );

  assign hit        = (cmd_r == CMD_FIND) && (rd_data_r == key_r);
  assign empty      = (rd_data_r == '0);
  assign last_probe = (cnt_r == SLOT_W'(TABLE_SIZE - 1));
  assign out_free   = !out_valid_r || out_tready;
  assign pos_sum    = {1'b0, pos_r} + {1'b0, step_r};
  assign pos_adv    = (pos_sum >= (SLOT_W+1)'(TABLE_SIZE)) ?
                      SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(pos_sum);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    found_nxt     = found_r;
    full_nxt      = full_r;
    slot_nxt      = slot_r;
    mem_re        = 1'b0;
    mem_raddr     = pos_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = key_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
        if (last_probe) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = cmd_t'(in_tuser);
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          key_nxt   = hash_key;
          pos_nxt   = hash_pos;
          step_nxt  = hash_step;
          cnt_nxt   = '0;
          mem_re    = 1'b1;
          mem_raddr = hash_pos;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit || empty || last_probe) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            found_nxt     = hit;
            full_nxt      = !(hit || empty);
            slot_nxt      = SLOT_OUT_W'(pos_r);
            mem_we        = (cmd_r == CMD_INSERT) && empty;
            state_nxt     = ST_IDLE;
          end
        end else begin
          pos_nxt   = pos_adv;
          cnt_nxt   = cnt_r + SLOT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = pos_adv;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    pos_r   <= pos_nxt;
    step_r  <= step_nxt;
    found_r <= found_nxt;
    full_r  <= full_nxt;
    slot_r  <= slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(slot_r);
  assign out_tuser  = {full_r, found_r};

endmodule

// ----- verif/double_hash_dictionary_tb.sv -----
// Self-checking testbench for the double hash dictionary: insert/find streams vs a shadow table.
`timescale 1ns / 100ps

module double_hash_dictionary_tb;
  import dhd_pkg::*;

  localparam int TBL_SIZE = TABLE_SIZE_DEF;
  localparam int STR_MAX  = MAX_LEN_DEF;

  typedef struct packed {
    logic        found;
    logic        full;
    logic [11:0] slot;
  } dict_reply_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [23:0] syms;
  } dna_str_t;

  class dict_shadow;
    bit [27:0]   keys [TBL_SIZE];
    dict_reply_t pending_replies[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function bit [27:0] dna_key(logic [3:0] len, logic [23:0] syms);
      int        n;
      bit [27:0] weight;
      bit [27:0] sum;
      n = len;
      if (n < 1) n = 1;
      if (n > STR_MAX) n = STR_MAX;
      weight = 1;
      sum    = 0;
      for (int i = 0; i < n; i++) begin
        sum    = sum + weight * (28'(syms[2*i +: 2]) + 28'd1);
        weight = weight * 28'd5;
      end
      return sum;
    endfunction

    // Walk the probe sequence and record the reply this transaction must produce.
    function void apply_item(cmd_t c, logic [3:0] len, logic [23:0] syms);
      bit [27:0]   key;
      int          pos;
      int          stride;
      dict_reply_t r;
      key    = dna_key(len, syms);
      pos    = key % TBL_SIZE;
      stride = 1 + key % (TBL_SIZE - 1);
      r.found = 1'b0;
      r.full  = 1'b1;
      r.slot  = pos[11:0];
      for (int probe = 0; probe < TBL_SIZE; probe++) begin
        r.slot = pos[11:0];
        if (c == CMD_FIND) begin
          if (keys[pos] == key) begin
            r.found = 1'b1;
            r.full  = 1'b0;
            break;
          end
          if (keys[pos] == 0) begin
            r.full = 1'b0;
            break;
          end
        end else if (keys[pos] == 0) begin
          keys[pos] = key;
          r.full = 1'b0;
          break;
        end
        pos += stride;
        if (pos >= TBL_SIZE) pos -= TBL_SIZE;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic found, logic full, logic [11:0] slot);
      dict_reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply found=%0b full=%0b slot=%0d", $time, found, full, slot);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (found !== e.found) begin
        $display("%0t: found mismatch exp=%0b act=%0b", $time, e.found, found);
        errors++;
      end
      if (full !== e.full) begin
        $display("%0t: table_full mismatch exp=%0b act=%0b", $time, e.full, full);
        errors++;
      end
      if (slot !== e.slot) begin
        $display("%0t: slot mismatch exp=%0d act=%0d", $time, e.slot, slot);
        errors++;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  dict_shadow shadow = new();
  dna_str_t   stored_q[$];
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_cycles    = 0;

  double_hash_dictionary u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready  = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      shadow.check_reply(out_tuser[0], out_tuser[1], out_tdata[11:0]);
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_item(input cmd_t c, input logic [3:0] len, input logic [23:0] syms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, syms, len};
    in_tuser  = c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.apply_item(c, len, syms);
    @(negedge clk);
  endtask

  task automatic random_item();
    int          pick;
    int          n;
    dna_str_t    s;
    logic [23:0] junk;
    pick = $urandom_range(99);
    if (pick < 45 || stored_q.size() == 0) begin
      case ($urandom_range(9))
        0:       s.len = 4'($urandom_range(15));
        1, 2, 3: s.len = 4'($urandom_range(1, 3));
        default: s.len = 4'($urandom_range(1, 12));
      endcase
      s.syms = 24'($urandom);
      stored_q.push_back(s);
      send_item(CMD_INSERT, s.len, s.syms);
    end else if (pick < 55) begin
      s = stored_q[$urandom_range(stored_q.size() - 1)];
      send_item(CMD_INSERT, s.len, s.syms);
    end else if (pick < 85) begin
      // same key, different encoding: junk above the string, alternate length codes
      s = stored_q[$urandom_range(stored_q.size() - 1)];
      n = s.len;
      if (n < 1) n = 1;
      if (n > STR_MAX) n = STR_MAX;
      if (n < 12) begin
        junk   = 24'($urandom) & ~((24'd1 << (2 * n)) - 24'd1);
        s.syms = s.syms ^ junk;
      end
      if (n == 12) s.len = 4'($urandom_range(12, 15));
      if (n == 1) s.len = 4'($urandom_range(1));
      send_item(CMD_FIND, s.len, s.syms);
    end else begin
      send_item(CMD_FIND, 4'($urandom_range(15)), 24'($urandom));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) random_item();
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_INSERT;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_item(CMD_INSERT, 4'd1,  24'h000000);
    send_item(CMD_FIND,   4'd1,  24'h000000);
    send_item(CMD_FIND,   4'd1,  24'h000001);
    send_item(CMD_INSERT, 4'd12, 24'hFFFFFF);
    send_item(CMD_FIND,   4'd15, 24'hFFFFFF);
    send_item(CMD_INSERT, 4'd0,  24'h000003);
    send_item(CMD_FIND,   4'd1,  24'hFFFFF3);
    send_item(CMD_INSERT, 4'd1,  24'h000000);
    send_item(CMD_INSERT, 4'd1,  24'h000000);
    send_item(CMD_FIND,   4'd0,  24'hFFFFFC);
    send_item(CMD_INSERT, 4'd13, 24'h000000);
    send_item(CMD_FIND,   4'd12, 24'h000000);
    send_item(CMD_INSERT, 4'd14, 24'hAAAAAA);
    send_item(CMD_FIND,   4'd12, 24'hAAAAAA);
    send_item(CMD_INSERT, 4'd8,  24'h555555);
    send_item(CMD_FIND,   4'd8,  24'hAA5555);
    send_item(CMD_FIND,   4'd9,  24'h555555);
    send_item(CMD_FIND,   4'd12, 24'h123456);

    run_phase(0, 0, 340);
    run_phase(78, 0, 340);
    run_phase(0, 78, 340);
    run_phase(30, 30, 340);

    // back-pressure: receiver holds off while items keep coming
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 500;
    repeat (60) random_item();
    run_phase(30, 30, 260);

    wait_drained();
    repeat (50) @(negedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dhd_pkg.sv
rtl/core/dhd_hash.sv
rtl/core/double_hash_dictionary.sv
verif/double_hash_dictionary_tb.sv
